// ----- rtl/pearson_correlation_defines.svh -----
// Assertion helpers for the file that carries checks.
`ifndef PEARSON_CORRELATION_DEFINES_SVH
`define PEARSON_CORRELATION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCORR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pearson_correlation: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCORR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pearson_correlation: check failed");

`endif

// ----- rtl/pcorr_pkg.sv -----
package pcorr_pkg;

    // Sample format and limits.
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_PAIRS   = 1024;
    localparam int CNT_W       = 11;

    // Accumulator widths.
    localparam int SX_W  = 27;
    localparam int SQ_W  = 41;
    localparam int SXY_W = 42;

    // Finishing arithmetic widths.
    localparam int PROD_W  = 56;
    localparam int NUM_W   = 54;
    localparam int VAR_W   = 52;
    localparam int PROD2_W = 2 * VAR_W;
    localparam int REM_W   = VAR_W + 4;
    localparam int Q_W     = 31;
    localparam int ITER_W  = $clog2(VAR_W);
    localparam int COEF_W  = 32;

    localparam logic [Q_W-1:0]           ONE_Q30  = Q_W'(31'h4000_0000);
    localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sd1073741824;
    localparam logic signed [COEF_W-1:0] COEF_MIN = -32'sd1073741824;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_VAR = 2'd1,
        STAT_OVERFLOW = 2'd2
    } status_e;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_sample;
        logic signed [SAMPLE_BITS-1:0] y_sample;
        logic                          last_pair;
    } sample_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [1:0]               status;
        logic [CNT_W-1:0]         pairs_used;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accumulate;
        logic    capture_products;
        logic    capture_diffs;
        logic    start_iter;
        logic    mul_step;
        logic    sqrt_step;
        logic    div_step;
        logic    cnt_clear;
        logic    load_result;
        status_e result_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic overflow;
        logic zero_var;
        logic wide_last;
        logic div_last;
    } dp_status_t;

endpackage

// ----- rtl/pearson_correlation.sv -----
// Pearson correlation of paired samples. Pairs are taken one per cycle, while
// the block accumulates, into running sums; the pair flagged last closes the
// set, after which the block forms products and differences, then runs the
// bit-serial multiply of the two variances, the digit-serial square root and
// the restoring division, sharing one iteration counter, before loading the
// result into an output register, so the next set may start while it waits.
`include "pearson_correlation_defines.svh"

module pearson_correlation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  pcorr_pkg::sample_t sample,
    output logic               result_valid,
    input  logic               result_ready,
    output pcorr_pkg::result_t result
);
    import pcorr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    // Sequencer.
    pcorr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .last_pair    (sample.last_pair),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Sums and finishing arithmetic.
    pcorr_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    // A flagged pair closes the set: no pair is taken in the next cycle.
    `PCORR_ASSERT_NEXT(a_set_closes, sample_valid && sample_ready && sample.last_pair, !sample_ready)
    // Special cases deliver a zero coefficient.
    `PCORR_ASSERT_IMPL(a_special_zero, result_valid && (result.status != STAT_OK), result.coefficient == '0)
    // The coefficient stays within plus and minus one.
    `PCORR_ASSERT_IMPL(a_coef_range, result_valid, (result.coefficient <= COEF_MAX) && (result.coefficient >= COEF_MIN))

endmodule

// ----- rtl/pcorr_dp.sv -----
module pcorr_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  pcorr_pkg::sample_t sample,
    input  pcorr_pkg::dp_cmd_t cmd,
    output pcorr_pkg::dp_status_t stat,
    output pcorr_pkg::result_t result
);
    import pcorr_pkg::*;

    // Running sums.
    logic [CNT_W-1:0]        count_reg;
    logic                    ovf_reg;
    logic signed [SX_W-1:0]  sx_reg, sy_reg;
    logic [SQ_W-1:0]         sxx_reg, syy_reg;
    logic signed [SXY_W-1:0] sxy_reg;

    // Finishing registers.
    logic signed [PROD_W-1:0] p_nxy_reg, p_xy_reg, p_nxx_reg, p_xx_reg, p_nyy_reg, p_yy_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [VAR_W-1:0]         vx_reg, vy_reg;
    logic [PROD2_W-1:0]       acc_reg, mcand_reg;
    logic [VAR_W-1:0]         mplier_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [VAR_W-1:0]         root_reg;
    logic [VAR_W:0]           dr_reg;
    logic [Q_W-1:0]           q_reg;
    logic [ITER_W-1:0]        iter_reg;
    result_t                  result_reg;

    logic signed [SX_W-1:0]          x_ext, y_ext;
    logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;
    logic signed [CNT_W:0]           n_s;
    logic signed [NUM_W-1:0]         mag_full;
    logic [VAR_W-1:0]                mag;
    logic                            neg;
    logic [REM_W-1:0]                rem_sh, trial;
    logic [VAR_W:0]                  dr_diff;
    logic                            dr_ge;
    logic [Q_W-1:0]                  q_clamped;
    logic signed [COEF_W-1:0]        coef;
    logic                            room;

    // Per-pair terms.
    assign x_ext = {{(SX_W-SAMPLE_BITS){sample.x_sample[SAMPLE_BITS-1]}}, sample.x_sample};
    assign y_ext = {{(SX_W-SAMPLE_BITS){sample.y_sample[SAMPLE_BITS-1]}}, sample.y_sample};
    assign xx    = sample.x_sample * sample.x_sample;
    assign yy    = sample.y_sample * sample.y_sample;
    assign xy    = sample.x_sample * sample.y_sample;
    assign room  = count_reg < CNT_W'(MAX_PAIRS);
    assign n_s   = {1'b0, count_reg};

    // Sign and magnitude of the numerator.
    assign neg      = num_reg[NUM_W-1];
    assign mag_full = neg ? -num_reg : num_reg;
    assign mag      = mag_full[VAR_W-1:0];

    // One square-root digit: two radicand bits enter per step.
    assign rem_sh = {rem_reg[REM_W-3:0], acc_reg[PROD2_W-1 -: 2]};
    assign trial  = {{(REM_W-VAR_W-2){1'b0}}, root_reg, 2'b01};

    // One quotient bit per division step.
    assign dr_ge   = dr_reg >= {1'b0, root_reg};
    assign dr_diff = dr_ge ? dr_reg - {1'b0, root_reg} : dr_reg;

    // Final coefficient with clamp.
    assign q_clamped = (q_reg > ONE_Q30) ? ONE_Q30 : q_reg;
    always_comb
    begin
        if (cmd.result_status != STAT_OK)
        begin
            coef = '0;
        end
        else if (neg)
        begin
            coef = -$signed({1'b0, q_clamped});
        end
        else
        begin
            coef = $signed({1'b0, q_clamped});
        end
    end

    // Accumulators, cleared when a result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
        end
        else if (cmd.load_result)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
        end
        else if (cmd.accumulate)
        begin
            if (room)
            begin
                count_reg <= count_reg + 1'b1;
                sx_reg    <= sx_reg + x_ext;
                sy_reg    <= sy_reg + y_ext;
                sxx_reg   <= sxx_reg + {{(SQ_W-2*SAMPLE_BITS){1'b0}}, xx};
                syy_reg   <= syy_reg + {{(SQ_W-2*SAMPLE_BITS){1'b0}}, yy};
                sxy_reg   <= sxy_reg + {{(SXY_W-2*SAMPLE_BITS){xy[2*SAMPLE_BITS-1]}}, xy};
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Products of the sums, then the three differences.
    always_ff @(posedge clk)
    begin
        if (cmd.capture_products)
        begin
            p_nxy_reg <= n_s * sxy_reg;
            p_xy_reg  <= sx_reg * sy_reg;
            p_nxx_reg <= n_s * $signed({1'b0, sxx_reg});
            p_xx_reg  <= sx_reg * sx_reg;
            p_nyy_reg <= n_s * $signed({1'b0, syy_reg});
            p_yy_reg  <= sy_reg * sy_reg;
        end
        if (cmd.capture_diffs)
        begin
            num_reg <= NUM_W'(p_nxy_reg - p_xy_reg);
            vx_reg  <= VAR_W'(p_nxx_reg - p_xx_reg);
            vy_reg  <= VAR_W'(p_nyy_reg - p_yy_reg);
        end
    end

    // Shift-add multiply, digit square root and restoring division.
    always_ff @(posedge clk)
    begin
        if (cmd.start_iter)
        begin
            acc_reg    <= '0;
            mcand_reg  <= {{(PROD2_W-VAR_W){1'b0}}, vx_reg};
            mplier_reg <= vy_reg;
            rem_reg    <= '0;
            root_reg   <= '0;
            dr_reg     <= {1'b0, mag};
            q_reg      <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PROD2_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[VAR_W-1:1]};
        end
        else if (cmd.sqrt_step)
        begin
            acc_reg <= {acc_reg[PROD2_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[VAR_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[VAR_W-2:0], 1'b0};
            end
        end
        else if (cmd.div_step)
        begin
            dr_reg <= {dr_diff[VAR_W-1:0], 1'b0};
            q_reg  <= {q_reg[Q_W-2:0], dr_ge};
        end
    end

    // Shared iteration counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (cmd.cnt_clear || cmd.start_iter)
        begin
            iter_reg <= '0;
        end
        else if (cmd.mul_step || cmd.sqrt_step || cmd.div_step)
        begin
            iter_reg <= iter_reg + 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            result_reg.coefficient <= coef;
            result_reg.status      <= cmd.result_status;
            result_reg.pairs_used  <= count_reg;
        end
    end

    assign stat.overflow  = ovf_reg;
    assign stat.zero_var  = (vx_reg == '0) || (vy_reg == '0);
    assign stat.wide_last = iter_reg == ITER_W'(VAR_W - 1);
    assign stat.div_last  = iter_reg == ITER_W'(Q_W - 1);
    assign result         = result_reg;

endmodule

// ----- rtl/pcorr_ctrl.sv -----
module pcorr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  last_pair,
    output logic                  sample_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  pcorr_pkg::dp_status_t stat,
    output pcorr_pkg::dp_cmd_t    cmd
);
    import pcorr_pkg::*;

    typedef enum logic [7:0] {
        S_ACC  = 8'b0000_0001,
        S_PROD = 8'b0000_0010,
        S_DIFF = 8'b0000_0100,
        S_CHK  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_SQRT = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    status_e code_reg, code_next;
    logic    valid_reg, valid_next;
    logic    slot_free;

    assign slot_free = !valid_reg || result_ready;

    // Sequencing of one set: accumulate, finish, deliver.
    always_comb
    begin
        state_next   = state_reg;
        code_next    = code_reg;
        cmd          = '0;
        cmd.result_status = code_reg;
        sample_ready = 1'b0;
        unique case (state_reg)
            S_ACC:
            begin
                sample_ready   = 1'b1;
                cmd.accumulate = sample_valid;
                if (sample_valid && last_pair)
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.capture_products = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.capture_diffs = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.overflow)
                begin
                    code_next  = STAT_OVERFLOW;
                    state_next = S_DONE;
                end
                else if (stat.zero_var)
                begin
                    code_next  = STAT_ZERO_VAR;
                    state_next = S_DONE;
                end
                else
                begin
                    code_next      = STAT_OK;
                    cmd.start_iter = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.wide_last)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.wide_last)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load_result)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            code_reg  <= STAT_OK;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;

endmodule
